// File: rtl/pwrcd_pkg.sv
`default_nettype none

package pwrcd_pkg;

  localparam int unsigned DurW      = 20;
  localparam int unsigned ShortW    = 12;
  localparam int unsigned LongW     = 13;
  localparam int unsigned TolW      = 12;
  localparam int unsigned MinBitsW  = 7;
  localparam int unsigned CodeW     = 64;
  localparam int unsigned CountW    = 8;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 13;

  localparam int unsigned HeaderUnits = 51;
  localparam int unsigned EndUnits    = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgShortUnit = 2'd0,
    CfgLongUnit  = 2'd1,
    CfgTolerance = 2'd2,
    CfgMinBits   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [ShortW-1:0]   short_unit;
    logic [LongW-1:0]    long_unit;
    logic [TolW-1:0]     tolerance;
    logic [MinBitsW-1:0] min_bits;
  } cfg_t;

  typedef struct packed {
    logic            level;
    logic [DurW-1:0] duration;
  } in_t;

  typedef struct packed {
    logic [CodeW-1:0]  code;
    logic [CountW-1:0] bit_count;
  } out_t;

  // Classified pulse as it sits in the queue
  typedef struct packed {
    logic            level;
    logic [DurW-1:0] duration;
    logic            hdr_hit;
    logic            end_hit;
    logic            near_short;
    logic            near_long;
  } cls_t;

  // |d - nom| < tol
  function automatic logic near(logic [DurW-1:0] d, logic [DurW-1:0] nom,
                                logic [DurW-1:0] tol);
    logic [DurW-1:0] diff;
    diff = (d > nom) ? (d - nom) : (nom - d);
    return diff < tol;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pulse_width_remote_code_decoder_top.sv
`default_nettype none

// Pulse-width remote code decoder. Each input transaction is one radio pulse
// (line level plus duration in microseconds). The decoder hunts for a low
// header of about 51 short units, then a short high start pulse, then reads
// low/high pairs: short-low/long-high is a 0, long-low/short-high is a 1,
// shifted MSB-first into a 64-bit code. A low of at least 4 short units ends
// the frame; if at least min_bits bits were taken, one output transaction
// carries the code and the saturating bit count. Anything unexpected drops
// back to header hunt. Throughput is one pulse per clock when nothing stalls:
// the front end classifies a pulse against the configured units in the
// accept cycle and writes it to a small queue; the back end steps the phase
// machine on one queued pulse per cycle and loads the output register. The
// queue and then the output register lie between input accept and output
// valid. Configuration registers (short_unit, long_unit, tolerance, min_bits)
// are written through cfg_we_i/cfg_idx_i/cfg_data_i and must only change
// while the decoder is idle. in_stall_o rises only when the queue is full.
module pulse_width_remote_code_decoder_top #(
  parameter int unsigned QueueDepth = 2  // pulse queue entries, at least 2
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input pulses
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire pwrcd_pkg::in_t                      in_data_i,
  // decoded frames
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output pwrcd_pkg::out_t                          out_data_o,
  // configuration writes
  input  wire logic                                cfg_we_i,
  input  wire logic [pwrcd_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [pwrcd_pkg::CfgDataW-1:0]      cfg_data_i
);

  pwrcd_pkg::cfg_t cfg_q, cfg_d;

  logic            enq_valid, enq_ready;
  pwrcd_pkg::cls_t enq_data;
  logic            deq_valid, deq_ready;
  pwrcd_pkg::cls_t deq_data;

  // Config register file, each field truncated to its own width
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pwrcd_pkg::cfg_idx_e'(cfg_idx_i))
        pwrcd_pkg::CfgShortUnit:
          cfg_d.short_unit = cfg_data_i[pwrcd_pkg::ShortW-1:0];
        pwrcd_pkg::CfgLongUnit:
          cfg_d.long_unit  = cfg_data_i[pwrcd_pkg::LongW-1:0];
        pwrcd_pkg::CfgTolerance:
          cfg_d.tolerance  = cfg_data_i[pwrcd_pkg::TolW-1:0];
        pwrcd_pkg::CfgMinBits:
          cfg_d.min_bits   = cfg_data_i[pwrcd_pkg::MinBitsW-1:0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_unit <= pwrcd_pkg::ShortW'(320);
      cfg_q.long_unit  <= pwrcd_pkg::LongW'(640);
      cfg_q.tolerance  <= pwrcd_pkg::TolW'(150);
      cfg_q.min_bits   <= pwrcd_pkg::MinBitsW'(12);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Front end: pulse classification at accept
  pwrcd_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .enq_valid_o (enq_valid),
    .enq_ready_i (enq_ready),
    .enq_data_o  (enq_data)
  );

  // Decoupling queue between classification and the phase machine
  pwrcd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enq_valid_i (enq_valid),
    .enq_ready_o (enq_ready),
    .enq_data_i  (enq_data),
    .deq_valid_o (deq_valid),
    .deq_ready_i (deq_ready),
    .deq_data_o  (deq_data)
  );

  // Back end: frame phase machine, shift register and output register
  pwrcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .deq_valid_i (deq_valid),
    .deq_ready_o (deq_ready),
    .deq_data_i  (deq_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: rtl/pwrcd_front.sv
`default_nettype none

module pwrcd_front (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire pwrcd_pkg::in_t    in_data_i,
  input  wire pwrcd_pkg::cfg_t   cfg_i,
  output logic                   enq_valid_o,
  input  wire logic              enq_ready_i,
  output pwrcd_pkg::cls_t        enq_data_o
);

  localparam int unsigned HdrW = 18;
  localparam int unsigned EndW = 14;

  logic [HdrW-1:0] hdr_nom;
  logic [HdrW-1:0] hdr_tol;
  logic [EndW-1:0] end_min;
  logic [pwrcd_pkg::DurW-1:0] dur;

  assign dur     = in_data_i.duration;
  assign hdr_nom = HdrW'(cfg_i.short_unit) * HdrW'(pwrcd_pkg::HeaderUnits);
  assign hdr_tol = HdrW'(cfg_i.tolerance) * HdrW'(pwrcd_pkg::HeaderUnits);
  assign end_min = EndW'(cfg_i.short_unit) * EndW'(pwrcd_pkg::EndUnits);

  always_comb begin
    enq_data_o.level      = in_data_i.level;
    enq_data_o.duration   = dur;
    enq_data_o.hdr_hit    = pwrcd_pkg::near(dur, pwrcd_pkg::DurW'(hdr_nom),
                                            pwrcd_pkg::DurW'(hdr_tol));
    enq_data_o.end_hit    = dur >= pwrcd_pkg::DurW'(end_min);
    enq_data_o.near_short = pwrcd_pkg::near(dur, pwrcd_pkg::DurW'(cfg_i.short_unit),
                                            pwrcd_pkg::DurW'(cfg_i.tolerance));
    enq_data_o.near_long  = pwrcd_pkg::near(dur, pwrcd_pkg::DurW'(cfg_i.long_unit),
                                            pwrcd_pkg::DurW'(cfg_i.tolerance));
  end

  assign enq_valid_o = in_valid_i;
  assign in_stall_o  = !enq_ready_i;

endmodule

`default_nettype wire

// File: rtl/pwrcd_fifo.sv
`default_nettype none

module pwrcd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             enq_valid_i,
  output logic                  enq_ready_o,
  input  wire pwrcd_pkg::cls_t  enq_data_i,
  output logic                  deq_valid_o,
  input  wire logic             deq_ready_i,
  output pwrcd_pkg::cls_t       deq_data_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pwrcd_pkg::cls_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic push, pop;

  assign enq_ready_o = count_q != CntW'(Depth);
  assign deq_valid_o = count_q != '0;
  assign deq_data_o  = mem_q[rd_ptr_q];
  assign push        = enq_valid_i && enq_ready_o;
  assign pop         = deq_valid_o && deq_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= enq_data_i;
    end
  end

endmodule

`default_nettype wire

// File: rtl/pwrcd_back.sv
`default_nettype none

module pwrcd_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire pwrcd_pkg::cfg_t  cfg_i,
  input  wire logic             deq_valid_i,
  output logic                  deq_ready_o,
  input  wire pwrcd_pkg::cls_t  deq_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output pwrcd_pkg::out_t       out_data_o
);

  typedef enum logic [1:0] {
    PhHunt  = 2'd0,
    PhStart = 2'd1,
    PhLow   = 2'd2,
    PhHigh  = 2'd3
  } phase_e;

  localparam logic [pwrcd_pkg::CountW-1:0] CountMax = '1;

  phase_e phase_q, phase_d;
  logic [pwrcd_pkg::CodeW-1:0]  shift_q, shift_d;
  logic [pwrcd_pkg::CountW-1:0] bits_q, bits_d;
  logic [pwrcd_pkg::DurW-1:0]   last_low_q, last_low_d;
  logic out_valid_q, out_valid_d;
  pwrcd_pkg::out_t out_data_q;

  logic fire, emit, push_bit, bit_val;
  logic ll_short, ll_long;

  assign deq_ready_o = !out_valid_q || !out_stall_i;
  assign fire        = deq_valid_i && deq_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign ll_short = pwrcd_pkg::near(last_low_q, pwrcd_pkg::DurW'(cfg_i.short_unit),
                                    pwrcd_pkg::DurW'(cfg_i.tolerance));
  assign ll_long  = pwrcd_pkg::near(last_low_q, pwrcd_pkg::DurW'(cfg_i.long_unit),
                                    pwrcd_pkg::DurW'(cfg_i.tolerance));

  always_comb begin
    phase_d    = phase_q;
    shift_d    = shift_q;
    bits_d     = bits_q;
    last_low_d = last_low_q;
    emit       = 1'b0;
    push_bit   = 1'b0;
    bit_val    = 1'b0;
    if (fire) begin
      case (phase_q)
        PhHunt: begin
          if (!deq_data_i.level && deq_data_i.hdr_hit) phase_d = PhStart;
        end
        PhStart: begin
          if (deq_data_i.level) begin
            if (deq_data_i.near_short) begin
              phase_d = PhLow;
              shift_d = '0;
              bits_d  = '0;
            end else begin
              phase_d = PhHunt;
            end
          end
        end
        PhLow: begin
          if (deq_data_i.level) begin
            phase_d = PhHunt;
          end else if (deq_data_i.end_hit) begin
            phase_d = PhStart;
            emit    = bits_q >= pwrcd_pkg::CountW'(cfg_i.min_bits);
          end else begin
            last_low_d = deq_data_i.duration;
            phase_d    = PhHigh;
          end
        end
        PhHigh: begin
          if (!deq_data_i.level) begin
            phase_d = PhHunt;
          end else if (ll_short && deq_data_i.near_long) begin
            push_bit = 1'b1;
            phase_d  = PhLow;
          end else if (ll_long && deq_data_i.near_short) begin
            push_bit = 1'b1;
            bit_val  = 1'b1;
            phase_d  = PhLow;
          end else begin
            phase_d = PhHunt;
          end
        end
        default: phase_d = PhHunt;
      endcase
    end
    if (push_bit) begin
      shift_d = {shift_q[pwrcd_pkg::CodeW-2:0], bit_val};
      if (bits_q != CountMax) bits_d = bits_q + pwrcd_pkg::CountW'(1);
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      shift_q     <= '0;
      bits_q      <= '0;
      last_low_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      shift_q     <= shift_d;
      bits_q      <= bits_d;
      last_low_q  <= last_low_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q.code      <= shift_q;
      out_data_q.bit_count <= bits_q;
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
module testbench;
  import pwrcd_pkg::*;

  // Generous bound on the whole run, in clock cycles. The slowest correct run
  // (every pulse behind the longest sender gap, every frame behind the longest
  // receiver stall, plus the long hold and the drains) stays well below this.
  localparam int unsigned CycleLimit = 500000;
  // Cycles allowed after the last expected frame before a register write.
  localparam int unsigned SettleCycles = 16;
  localparam longint MaxDur = (longint'(1) << DurW) - 1;

  // Decoder phases, as the predictor tracks them.
  typedef enum logic [1:0] {
    SeekHeader,
    SeekStart,
    SeekLow,
    SeekHigh
  } seek_e;

  // Predicts decoded frames from accepted pulses. It also holds the frames
  // still owed by the block and checks each returned frame against the oldest.
  class frame_tracker;
    logic [ShortW-1:0]   short_unit;
    logic [LongW-1:0]    long_unit;
    logic [TolW-1:0]     tolerance;
    logic [MinBitsW-1:0] min_bits;

    seek_e             phase;
    logic [CodeW-1:0]  shift_code;
    logic [CountW-1:0] bits_taken;
    logic [DurW-1:0]   low_half;

    out_t frames_due[$];
    int unsigned pulses_seen;
    int unsigned frames_predicted;
    int unsigned frames_matched;
    int unsigned mismatches;

    function new();
      short_unit = 12'd320;
      long_unit = 13'd640;
      tolerance = 12'd150;
      min_bits = 7'd12;
      phase = SeekHeader;
      shift_code = '0;
      bits_taken = '0;
      low_half = '0;
      pulses_seen = 0;
      frames_predicted = 0;
      frames_matched = 0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CfgDataW-1:0] v);
      case (idx)
        CfgShortUnit: short_unit = v[ShortW-1:0];
        CfgLongUnit:  long_unit = v[LongW-1:0];
        CfgTolerance: tolerance = v[TolW-1:0];
        CfgMinBits:   min_bits = v[MinBitsW-1:0];
        default: ;
      endcase
    endfunction

    static function bit close_to(int unsigned d, int unsigned nom, int unsigned tol);
      int unsigned diff;
      diff = (d > nom) ? d - nom : nom - d;
      return diff < tol;
    endfunction

    function void push_bit(bit b);
      shift_code = {shift_code[CodeW-2:0], b};
      if (bits_taken != {CountW{1'b1}}) bits_taken++;
    endfunction

    function void note_pulse(in_t p);
      int unsigned d;
      int unsigned s;
      int unsigned t;
      out_t f;
      d = 32'(p.duration);
      s = 32'(short_unit);
      t = 32'(tolerance);
      pulses_seen++;
      case (phase)
        SeekHeader: begin
          if (!p.level && close_to(d, s * HeaderUnits, t * HeaderUnits)) phase = SeekStart;
        end
        SeekStart: begin
          if (p.level) begin
            if (close_to(d, s, t)) begin
              phase = SeekLow;
              shift_code = '0;
              bits_taken = '0;
            end else begin
              phase = SeekHeader;
            end
          end
        end
        SeekLow: begin
          if (p.level) begin
            phase = SeekHeader;
          end else if (d >= s * EndUnits) begin
            phase = SeekStart;
            if (bits_taken >= min_bits) begin
              f.code = shift_code;
              f.bit_count = bits_taken;
              frames_due.push_back(f);
              frames_predicted++;
            end
          end else begin
            low_half = p.duration;
            phase = SeekHigh;
          end
        end
        default: begin
          if (!p.level) begin
            phase = SeekHeader;
          end else if (close_to(32'(low_half), s, t) && close_to(d, 32'(long_unit), t)) begin
            push_bit(1'b0);
            phase = SeekLow;
          end else if (close_to(32'(low_half), 32'(long_unit), t) && close_to(d, s, t)) begin
            push_bit(1'b1);
            phase = SeekLow;
          end else begin
            phase = SeekHeader;
          end
        end
      endcase
    endfunction

    function void check_frame(out_t got);
      out_t want;
      if (frames_due.size() == 0) begin
        $error("unexpected frame: code %h bit_count %0d", got.code, got.bit_count);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      if (got.code !== want.code) begin
        $error("code: expected %h, got %h", want.code, got.code);
        mismatches++;
      end
      if (got.bit_count !== want.bit_count) begin
        $error("bit_count: expected %0d, got %0d", want.bit_count, got.bit_count);
        mismatches++;
      end
      frames_matched++;
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction
  endclass

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  in_t      in_data;
  logic     out_valid;
  logic     out_stall;
  out_t     out_data;
  logic     cfg_we;
  cfg_idx_e cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  frame_tracker tracker;
  int unsigned  gap_pct;        // chance in percent of a sender gap before a pulse
  bit           calm;           // closing stretch: no idling on either side
  int unsigned  settings_used;
  int unsigned  cycles;

  pulse_width_remote_code_decoder_top uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Duration helpers. All of them read the current settings from the tracker.
  // ---------------------------------------------------------------------------

  function automatic logic [DurW-1:0] clamp_dur(longint v);
    if (v < 0) return '0;
    if (v > MaxDur) return {DurW{1'b1}};
    return v[DurW-1:0];
  endfunction

  // A duration that still counts as near nom: strictly inside the tolerance,
  // with the inner edges picked now and then.
  function automatic logic [DurW-1:0] around(int unsigned nom, int unsigned tol);
    longint off;
    int unsigned r;
    if (tol <= 1) return clamp_dur(longint'(nom));
    r = $urandom_range(9);
    if (r == 0) off = longint'(tol) - 1;
    else if (r == 1) off = 1 - longint'(tol);
    else off = longint'($urandom_range(2 * tol - 2)) - (longint'(tol) - 1);
    return clamp_dur(longint'(nom) + off);
  endfunction

  // Noise: full-range values, the extremes, near misses just outside the
  // tolerance, and stray header-like lows.
  function automatic logic [DurW-1:0] random_duration();
    int unsigned s;
    int unsigned l;
    int unsigned t;
    s = 32'(tracker.short_unit);
    l = 32'(tracker.long_unit);
    t = 32'(tracker.tolerance);
    case ($urandom_range(6))
      0: return DurW'($urandom);
      1: return DurW'($urandom_range(0, 2 * l + 16));
      2: return $urandom_range(1) ? {DurW{1'b1}} : {DurW{1'b0}};
      3: return clamp_dur(longint'(s) + longint'(t));
      4: return clamp_dur(longint'(l) - longint'(t));
      5: return clamp_dur(longint'(s) - longint'(t));
      default: return around(s * HeaderUnits, t * HeaderUnits);
    endcase
  endfunction

  // Low that closes a frame; sometimes one short of the end threshold so the
  // frame runs on instead.
  function automatic logic [DurW-1:0] frame_end();
    longint lim;
    lim = longint'(tracker.short_unit) * EndUnits;
    case ($urandom_range(7))
      0: return clamp_dur(lim);
      1: return clamp_dur(lim - 1);
      2: return {DurW{1'b1}};
      default: return clamp_dur(lim + $urandom_range(0, 3000));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Tasks start and end right after a rising edge; inputs change
  // on the falling edge only.
  // ---------------------------------------------------------------------------

  task automatic pause_sender(int unsigned n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // One pulse transaction: offer it and hold it until the block takes it.
  task automatic send_pulse(bit lvl, logic [DurW-1:0] dur);
    in_t p;
    if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct)
      pause_sender($urandom_range(1, 15));
    p.level = lvl;
    p.duration = dur;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (in_stall);
    tracker.note_pulse(p);
  endtask

  // Well-formed bit pairs with random content; one pair may be replaced by a
  // single noise pulse to break the frame.
  task automatic send_bits(int unsigned nbits, int corrupt_at);
    int unsigned s;
    int unsigned l;
    int unsigned t;
    s = 32'(tracker.short_unit);
    l = 32'(tracker.long_unit);
    t = 32'(tracker.tolerance);
    for (int i = 0; i < nbits; i++) begin
      if (i == corrupt_at) begin
        send_pulse(1'($urandom_range(1)), random_duration());
      end else if ($urandom_range(1)) begin
        send_pulse(1'b0, around(l, t));
        send_pulse(1'b1, around(s, t));
      end else begin
        send_pulse(1'b0, around(s, t));
        send_pulse(1'b1, around(l, t));
      end
    end
  endtask

  // Without a header the frame relies on the previous frame end, which
  // leaves the decoder waiting for a start pulse.
  task automatic send_frame(bit with_header, int unsigned nbits, int corrupt_at);
    int unsigned s;
    int unsigned t;
    s = 32'(tracker.short_unit);
    t = 32'(tracker.tolerance);
    if (with_header) send_pulse(1'b0, around(s * HeaderUnits, t * HeaderUnits));
    send_pulse(1'b1, around(s, t));
    send_bits(nbits, corrupt_at);
    send_pulse(1'b0, frame_end());
  endtask

  // Mostly well-formed frames, some repeats without header, some broken
  // frames, some loose noise. Runs until both the pulse budget and the
  // number of predicted frames are reached.
  task automatic run_mix(int unsigned budget, int unsigned frames_wanted,
                         int unsigned lo_bits, int unsigned hi_bits);
    int unsigned first_pulse;
    int unsigned first_frame;
    int unsigned n;
    int unsigned pick;
    first_pulse = tracker.pulses_seen;
    first_frame = tracker.frames_predicted;
    while (tracker.pulses_seen - first_pulse < budget ||
           tracker.frames_predicted - first_frame < frames_wanted) begin
      case ($urandom_range(2))
        0: gap_pct = 0;
        1: gap_pct = 8;
        default: gap_pct = 35;
      endcase
      n = $urandom_range(lo_bits, hi_bits);
      pick = $urandom_range(99);
      if (pick < 55) send_frame(1'b1, n, -1);
      else if (pick < 75) send_frame(1'b0, n, -1);
      else if (pick < 88 && n != 0) send_frame(1'b1, n, int'($urandom_range(n - 1)));
      else repeat ($urandom_range(1, 4)) send_pulse(1'($urandom_range(1)), random_duration());
    end
  endtask

  // Stop sending, wait for every owed frame, then let the pipeline run dry.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Bits above the register width carry random junk; the block drops them.
  task automatic write_reg(cfg_idx_e idx, int unsigned value, int unsigned width);
    logic [CfgDataW-1:0] v;
    v = CfgDataW'(($urandom << width) | (value & ((32'd1 << width) - 1)));
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk);
    tracker.set_reg(idx, v);
  endtask

  task automatic apply_settings(int unsigned s, int unsigned l, int unsigned t, int unsigned m);
    settle();
    write_reg(CfgShortUnit, s, ShortW);
    write_reg(CfgLongUnit, l, LongW);
    write_reg(CfgTolerance, t, TolW);
    write_reg(CfgMinBits, m, MinBitsW);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stall bursts and free runs, one long hold once a
  // few frames have come back, and no stalls in the closing stretch.
  // ---------------------------------------------------------------------------
  initial begin : frame_sink
    int unsigned busy;
    int unsigned free_run;
    int unsigned hold;
    bit          hold_done;
    bit          stall;
    busy = 0;
    free_run = 0;
    hold = 0;
    hold_done = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && tracker.frames_matched >= 2) begin
        // long hold: the sender keeps offering, so queue and output fill up
        hold = 400;
        hold_done = 1;
      end
      if (hold != 0) begin
        hold--;
        stall = 1'b1;
      end else if (calm) begin
        stall = 1'b0;
      end else if (busy != 0) begin
        busy--;
        stall = 1'b1;
      end else if (free_run != 0) begin
        free_run--;
        stall = 1'b0;
      end else begin
        busy = $urandom_range(0, 14);
        free_run = ($urandom_range(3) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 20);
        stall = 1'b1;
      end
      out_stall <= stall;
    end
  end

  // Every frame transaction is checked at the edge that accepts it.
  initial begin : frame_monitor
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) tracker.check_frame(out_data);
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timed out after %0d cycles, %0d frames still owed", cycles, tracker.pending());
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned s;
    int unsigned l;
    int unsigned t;
    int unsigned m;
    int unsigned hdr;
    int unsigned hspread;
    logic [11:0] pattern;
    tracker = new();
    settings_used = 1;
    calm = 1'b0;
    gap_pct = 10;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = CfgShortUnit;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    // Directed part at the reset settings.
    s = 32'(tracker.short_unit);
    l = 32'(tracker.long_unit);
    t = 32'(tracker.tolerance);
    hdr = s * HeaderUnits;
    hspread = t * HeaderUnits - 1;
    send_pulse(1'b1, '0);                     // noise while hunting
    send_pulse(1'b0, {DurW{1'b1}});           // saturated low, not a header
    send_pulse(1'b0, DurW'(hdr + hspread));   // header at the upper edge
    send_pulse(1'b0, DurW'(5));               // low while waiting for start: ignored
    send_pulse(1'b1, DurW'(s + t));           // start just outside tolerance: back to hunt
    send_pulse(1'b0, DurW'(hdr - hspread));   // header at the lower edge
    send_pulse(1'b1, DurW'(s - t + 1));       // start at the lower edge
    pattern = 12'hA5C;
    for (int i = 11; i >= 0; i--) begin
      // alternate exact nominals and tolerance edges
      if (pattern[i]) begin
        send_pulse(1'b0, DurW'((i % 2) ? l + t - 1 : l));
        send_pulse(1'b1, DurW'((i % 2) ? s : s - t + 1));
      end else begin
        send_pulse(1'b0, DurW'((i % 2) ? s + t - 1 : s));
        send_pulse(1'b1, DurW'((i % 2) ? l : l - t + 1));
      end
    end
    send_pulse(1'b0, DurW'(s * EndUnits));     // end exactly at the threshold: frame out
    send_pulse(1'b1, DurW'(s));                // start again without header
    send_pulse(1'b0, DurW'(s * EndUnits - 1)); // just below the end: a low half
    send_pulse(1'b0, DurW'(s));                // low where a high half belongs: hunt

    // Reset settings, random traffic; the long receiver hold lands here.
    run_mix(60, 4, 12, 13);
    settle();                             // sender waits for every owed frame
    run_mix(60, 3, 12, 13);

    // Frames report even with no bits.
    apply_settings(320, 640, 150, 0);
    run_mix(40, 5, 0, 4);

    // Zero short unit: every low after the start ends the frame.
    apply_settings(0, 640, 150, 0);
    run_mix(30, 5, 0, 2);

    // Zero tolerance: nothing is ever near, no header is found.
    apply_settings(320, 640, 0, 12);
    run_mix(30, 0, 4, 8);

    // Zero long unit and the widest min_bits; one frame past 255 bits
    // saturates the count and keeps only the last 64 bits of code.
    apply_settings(100, 0, 40, 127);
    gap_pct = 0;
    send_frame(1'b1, 260, -1);

    // Largest units and tolerance; overlapping windows.
    apply_settings(4095, 8191, 4095, 8);
    run_mix(0, 1, 8, 10);

    // Random but decodable settings.
    repeat (3) begin
      s = $urandom_range(40, 600);
      l = 2 * s + $urandom_range(0, s / 2);
      t = $urandom_range(1, s / 3);
      m = $urandom_range(1, 8);
      apply_settings(s, l, t, m);
      run_mix(40, 1, 4, 12);
    end

    // Fully random register contents.
    apply_settings($urandom, $urandom, $urandom, $urandom);
    run_mix(20, 0, 0, 8);

    // Closing stretch without idling on either side.
    calm = 1'b1;
    apply_settings(320, 640, 150, 1);
    run_mix(80, 5, 1, 12);

    settle();
    $display("Sent %0d pulses under %0d register settings; checked %0d decoded frames.",
             tracker.pulses_seen, settings_used, tracker.frames_matched);
    $display("Covered header hunt, broken frames, count saturation and zero-unit corners.");
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/pwrcd_pkg.sv
rtl/pwrcd_front.sv
rtl/pwrcd_fifo.sv
rtl/pwrcd_back.sv
rtl/pulse_width_remote_code_decoder_top.sv
bench/testbench.sv
